// File: design/ppc_pkg.sv
// Shared types, constants and CORDIC angle table for the polar pose controller.
// No dependencies.
package ppc_pkg;

  localparam int unsigned MAX_SPEED_DEF     = 65536;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned XW                = 36;
  localparam int unsigned CFG_IW            = 4;
  localparam logic [29:0] CORDIC_K_Q30      = 30'd652032874;
  localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;
  localparam logic signed [31:0] SIXTH_TURN   = 32'sd10923;

  typedef enum logic [CFG_IW-1:0] {
    CFG_GOAL_X       = 4'd0,
    CFG_GOAL_Y       = 4'd1,
    CFG_GOAL_HEADING = 4'd2,
    CFG_DIST_TOL     = 4'd3,
    CFG_HEAD_TOL     = 4'd4,
    CFG_SPEED_GAIN   = 4'd5,
    CFG_BEARING_GAIN = 4'd6,
    CFG_FINAL_GAIN   = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic               done_res;
    logic [30:0]        speed;
    logic signed [31:0] turn_rate;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] goal_heading;
    logic [30:0]        distance_tolerance;
    logic [15:0]        heading_tolerance;
    logic [15:0]        speed_gain;
    logic [15:0]        bearing_gain;
    logic signed [15:0] final_angle_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic               neg;
    logic               zero;
    logic               hd_ok;
    logic signed [15:0] hd;
  } q_item_t;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

// File: design/polar_pose_controller.sv
// Top level of the polar pose controller: front end, request queue, back end.
// Depends on ppc_pkg, ppc_front, ppc_queue, ppc_back.
//
//   channel  handshake          payload
//   in       start / busy       in_data (pos_x, pos_y, heading)
//   out      out_valid strobe   out_data (done_res, speed, turn_rate)
//   cfg      cfg_valid/ready    cfg_index, cfg_data
//
// One request per cycle; the result strobe follows the accepting edge through the
// queue slot, the CORDIC input register, the unrolled stages (capped at 32),
// two scaling registers and two command-law registers.
// The back end never stalls, so busy stays low in operation.
// Reset is synchronous, active low; configuration takes effect next cycle.
module polar_pose_controller #(
  parameter int unsigned MAX_SPEED     = ppc_pkg::MAX_SPEED_DEF,
  parameter int unsigned CORDIC_STAGES = ppc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  ppc_pkg::in_item_t          in_data,
  output logic                       out_valid,
  output ppc_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ppc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                cfg_data
);
  import ppc_pkg::*;

  cfg_t    cfg;
  q_item_t f_item, q_item;
  logic    q_empty, q_full, push;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign push      = start && !q_full;

  ppc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cfg       (cfg),
    .item      (f_item)
  );

  ppc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (f_item),
    .pop       (!q_empty),
    .pop_data  (q_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  ppc_back #(
    .MAX_SPEED     (MAX_SPEED),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (!q_empty),
    .in_item   (q_item),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: design/ppc_front.sv
// Front end: configuration registers, goal difference and heading-error check.
// Depends on ppc_pkg.
module ppc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [ppc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_data,
  input  ppc_pkg::in_item_t in_data,
  output ppc_pkg::cfg_t     cfg,
  output ppc_pkg::q_item_t  item
);
  import ppc_pkg::*;

  cfg_t cfg_r;
  logic signed [32:0] dx, dy;
  logic signed [33:0] dx_e, dy_e;
  logic signed [15:0] herr;
  logic [16:0]        herr_abs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_x             <= '0;
      cfg_r.goal_y             <= '0;
      cfg_r.goal_heading       <= '0;
      cfg_r.distance_tolerance <= 31'd6554;
      cfg_r.heading_tolerance  <= 16'd910;
      cfg_r.speed_gain         <= 16'd256;
      cfg_r.bearing_gain       <= 16'd512;
      cfg_r.final_angle_gain   <= -16'sd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GOAL_X:       cfg_r.goal_x             <= cfg_data;
        CFG_GOAL_Y:       cfg_r.goal_y             <= cfg_data;
        CFG_GOAL_HEADING: cfg_r.goal_heading       <= cfg_data[15:0];
        CFG_DIST_TOL:     cfg_r.distance_tolerance <= cfg_data[30:0];
        CFG_HEAD_TOL:     cfg_r.heading_tolerance  <= cfg_data[15:0];
        CFG_SPEED_GAIN:   cfg_r.speed_gain         <= cfg_data[15:0];
        CFG_BEARING_GAIN: cfg_r.bearing_gain       <= cfg_data[15:0];
        CFG_FINAL_GAIN:   cfg_r.final_angle_gain   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  always_comb begin
    dx = 33'(cfg_r.goal_x) - 33'(in_data.pos_x);
    dy = 33'(cfg_r.goal_y) - 33'(in_data.pos_y);
    dx_e = 34'(dx);
    dy_e = 34'(dy);
    herr = cfg_r.goal_heading - in_data.heading;
    herr_abs = herr[15] ? 17'(-(17'(herr))) : {1'b0, herr};
    item.neg   = dx[32];
    item.x     = dx[32] ? -dx_e : dx_e;
    item.y     = dx[32] ? -dy_e : dy_e;
    item.zero  = (dx == '0) && (dy == '0);
    item.hd_ok = herr_abs < {1'b0, cfg_r.heading_tolerance};
    item.hd    = in_data.heading;
  end

endmodule

// File: design/ppc_queue.sv
// Two-entry request queue between front and back end.
// Depends on ppc_pkg.
module ppc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ppc_pkg::q_item_t push_data,
  input  logic             pop,
  output ppc_pkg::q_item_t pop_data,
  output logic             empty,
  output logic             full
);
  import ppc_pkg::*;

  q_item_t mem [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  assign pop_data = mem[rptr_r];
  assign empty    = (count_r == 2'd0);
  assign full     = (count_r == 2'd2);

endmodule

// File: design/ppc_back.sv
// Back end: CORDIC vectoring pipeline, distance scaling and command law.
// Depends on ppc_pkg.
module ppc_back #(
  parameter int unsigned MAX_SPEED     = ppc_pkg::MAX_SPEED_DEF,
  parameter int unsigned CORDIC_STAGES = ppc_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  ppc_pkg::q_item_t   in_item,
  input  ppc_pkg::cfg_t      cfg,
  output logic               out_valid,
  output ppc_pkg::out_item_t out_data
);
  import ppc_pkg::*;

  localparam int unsigned NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  typedef struct packed {
    logic               zero;
    logic               hd_ok;
    logic signed [15:0] hd;
  } meta_t;

  logic signed [XW-1:0] x_r [NS+1];
  logic signed [XW-1:0] y_r [NS+1];
  logic [31:0]          z_r [NS+1];
  logic                 v_r [NS+1];
  meta_t                m_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else        v_r[0] <= in_vld;
    x_r[0] <= XW'(in_item.x);
    y_r[0] <= XW'(in_item.y);
    z_r[0] <= in_item.neg ? 32'h80000000 : 32'h0;
    m_r[0] <= '{zero: in_item.zero, hd_ok: in_item.hd_ok, hd: in_item.hd};
  end

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k+1] <= 1'b0;
      else        v_r[k+1] <= v_r[k];
      if (!y_r[k][XW-1]) begin
        x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] + ATAN_TAB[k];
      end else begin
        x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] - ATAN_TAB[k];
      end
      m_r[k+1] <= m_r[k];
    end
  end

  // scale magnitude by K in two partial products
  logic        va_r;
  meta_t       ma_r;
  logic [46:0] ph_r, pl_r;
  logic [31:0] za_r;
  logic [31:0] zrnd;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= v_r[NS];
    ph_r <= 47'(x_r[NS][33:17]) * 47'(CORDIC_K_Q30);
    pl_r <= 47'(x_r[NS][16:0]) * 47'(CORDIC_K_Q30);
    za_r <= z_r[NS];
    ma_r <= m_r[NS];
  end

  logic        vb_r;
  meta_t       mb_r;
  logic [33:0] r_r;
  logic signed [15:0] bear_r;
  logic [64:0] rsum;

  assign rsum = {ph_r, 17'b0} + 65'(pl_r) + 65'(33'h20000000);
  assign zrnd = za_r + 32'h8000;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= va_r;
    r_r    <= ma_r.zero ? '0 : rsum[63:30];
    bear_r <= ma_r.zero ? '0 : zrnd[31:16];
    mb_r   <= ma_r;
  end

  // command law: products
  logic signed [15:0] alpha, beta;
  logic        vc_r, done_r, rot_r, apos_r;
  logic [49:0] ps_r;
  logic signed [32:0] pa_r;
  logic signed [31:0] pb_r;

  assign alpha = bear_r - mb_r.hd;
  assign beta  = cfg.goal_heading - mb_r.hd - alpha;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else        vc_r <= vb_r;
    done_r <= (r_r < 34'(cfg.distance_tolerance)) && mb_r.hd_ok;
    rot_r  <= (alpha >= QUARTER_TURN) || (alpha <= -QUARTER_TURN);
    apos_r <= alpha > 16'sd0;
    ps_r   <= 50'(cfg.speed_gain) * 50'(r_r);
    pa_r   <= $signed({17'b0, cfg.bearing_gain}) * 33'(alpha);
    pb_r   <= 32'(cfg.final_angle_gain) * 32'(beta);
  end

  logic [41:0] spd;
  logic signed [34:0] tsum;
  logic signed [26:0] tsh;
  logic [30:0] spd_cap;
  logic signed [31:0] turn_sat;

  always_comb begin
    spd  = 42'((ps_r + 50'd128) >> 8);
    spd_cap = (spd > 42'(MAX_SPEED)) ? 31'(MAX_SPEED) : spd[30:0];
    tsum = 35'(pa_r) + 35'(pb_r) + 35'sd128;
    tsh  = 27'(tsum >>> 8);
    turn_sat = 32'(tsh);
  end

  out_item_t res_r;
  logic      ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= vc_r;
    if (done_r) begin
      res_r <= '{done_res: 1'b1, speed: '0, turn_rate: '0};
    end else if (rot_r) begin
      res_r <= '{done_res: 1'b0, speed: '0,
                 turn_rate: apos_r ? SIXTH_TURN : -SIXTH_TURN};
    end else begin
      res_r <= '{done_res: 1'b0, speed: spd_cap, turn_rate: turn_sat};
    end
  end

  assign out_valid = ov_r;
  assign out_data  = res_r;

endmodule
